/* sv/cdoc_pkg.sv */
// ----------------------------------------------------------------------------
// cdoc_pkg: shared constants and tables for the civil date offset calculator
// Reciprocal multipliers for the constant divisions, month tables and the
// record that rides alongside the inverse date conversion.
// ----------------------------------------------------------------------------
package cdoc_pkg;

  localparam int unsigned STAGES    = 10;
  localparam int unsigned ERA_DAYS  = 146097;
  // 306 days of the March-based shift plus one era of year bias
  localparam int unsigned EPOCH_ADJ = 146403;
  // one era of bias plus the 305-day offset to 0000-03-01
  localparam int unsigned SHIFT_ADJ = 146402;

  // floor(x / d) == (x * ceil(2^k / d)) >> k whenever 2^k > x_max * d
  localparam int unsigned Q100_SH    = 22;
  localparam logic [15:0] Q100_MUL   = 16'(((64'd1 << Q100_SH) + 64'd99) / 64'd100);
  localparam int unsigned Q400_SH    = 24;
  localparam logic [15:0] Q400_MUL   = 16'(((64'd1 << Q400_SH) + 64'd399) / 64'd400);
  localparam int unsigned ERA_SH     = 41;
  localparam logic [23:0] ERA_MUL    =
    24'(((64'd1 << ERA_SH) + 64'(ERA_DAYS) - 64'd1) / 64'(ERA_DAYS));
  localparam int unsigned Q1460_SH   = 29;
  localparam logic [18:0] Q1460_MUL  = 19'(((64'd1 << Q1460_SH) + 64'd1459) / 64'd1460);
  localparam int unsigned Q36524_SH  = 34;
  localparam logic [18:0] Q36524_MUL =
    19'(((64'd1 << Q36524_SH) + 64'd36523) / 64'd36524);
  localparam int unsigned Q365_SH    = 27;
  localparam logic [18:0] Q365_MUL   = 19'(((64'd1 << Q365_SH) + 64'd364) / 64'd365);
  localparam int unsigned Q100Y_SH   = 16;
  localparam logic [9:0]  Q100Y_MUL  = 10'(((64'd1 << Q100Y_SH) + 64'd99) / 64'd100);
  localparam int unsigned Q153_SH    = 19;
  localparam logic [11:0] Q153_MUL   = 12'(((64'd1 << Q153_SH) + 64'd152) / 64'd153);

  // fields that travel down the pipe beside the inverse conversion
  typedef struct packed {
    logic [21:0] day_number;
    logic [4:0]  month_length;
    logic [2:0]  weekday;
    logic [5:0]  era;
  } carry_t;

  // (153 * k + 2) / 5: days from 1 March to the start of month k (k = 0 is March)
  function automatic logic [8:0] cum_days(input logic [3:0] k);
    logic [8:0] r;
    unique case (k)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      4'd12:   r = 9'd367;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    unique case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   r = 5'd30;
      4'd2:                                      r = leap ? 5'd29 : 5'd28;
      default:                                   r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

/* sv/civil_date_offset_calculator.sv */
// ----------------------------------------------------------------------------
// civil_date_offset_calculator: serial day, weekday and month length of a
// Gregorian date, and the date a signed number of days earlier.
// ----------------------------------------------------------------------------
//  channel | handshake               | word
//  --------+-------------------------+------------------------------------------
//  date    | date_valid / date_stall | year, month, day, days_back
//  answer  | answer_valid /          | day_number, weekday, month_length,
//          |   answer_stall          |   result_year/month/day, result_valid
//
//  Ten register stages: one word enters per cycle while date_stall is low.
//  Depth is set by the chain of reciprocal multiplies of the era/year-of-era
//  inverse, at most one multiply deep per stage except stage 8, which has two.
//  Reset clears the stage valid bits only.
//  A stage takes a new word when it is empty or the stage after it moves, so
//  bubbles close up under answer_stall and nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module civil_date_offset_calculator (
  input  logic               clk,
  input  logic               rst,
  input  logic               date_valid,
  output logic               date_stall,
  input  logic [13:0]        year,
  input  logic [3:0]         month,
  input  logic [4:0]         day,
  input  logic signed [15:0] days_back,
  output logic               answer_valid,
  input  logic               answer_stall,
  output logic [21:0]        day_number,
  output logic [2:0]         weekday,
  output logic [4:0]         month_length,
  output logic [13:0]        result_year,
  output logic [3:0]         result_month,
  output logic [4:0]         result_day,
  output logic               result_valid
);
  import cdoc_pkg::*;

  logic [STAGES-1:0] v;
  logic [STAGES-1:0] v_next;
  logic [STAGES-1:0] en;

  // a stage loads when empty or when the next one loads
  assign en         = ~v | {~answer_stall, en[STAGES-1:1]};
  assign v_next     = ({v[STAGES-2:0], date_valid} & en) | (v & ~en);
  assign date_stall = ~en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= v_next;
    end
  end

  // ---------------- stage 0: year bias and the year quotients
  logic [14:0]        yy_c;
  logic [3:0]         k_c;
  logic [7:0]         q100_c;
  logic [5:0]         q400_c;
  logic [7:0]         qy_c;
  logic [14:0]        s0_yy;
  logic [3:0]         s0_k;
  logic [7:0]         s0_q100;
  logic [5:0]         s0_q400;
  logic [7:0]         s0_qy;
  logic [13:0]        s0_year;
  logic [3:0]         s0_month;
  logic [4:0]         s0_day;
  logic signed [15:0] s0_back;

  // January and February count as months 13 and 14 of the year before
  assign yy_c   = 15'(year) + ((month <= 4'd2) ? 15'd399 : 15'd400);
  assign k_c    = (month <= 4'd2) ? month + 4'd9 : month - 4'd3;
  assign q100_c = 8'((32'(yy_c) * 32'(Q100_MUL)) >> Q100_SH);
  assign q400_c = 6'((32'(yy_c) * 32'(Q400_MUL)) >> Q400_SH);
  assign qy_c   = 8'((32'(year) * 32'(Q100_MUL)) >> Q100_SH);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_yy    <= yy_c;
      s0_k     <= k_c;
      s0_q100  <= q100_c;
      s0_q400  <= q400_c;
      s0_qy    <= qy_c;
      s0_year  <= year;
      s0_month <= month;
      s0_day   <= day;
      s0_back  <= days_back;
    end
  end

  // ---------------- stage 1: serial day and month length
  logic [22:0]        pos_c;
  logic [17:0]        neg_c;
  logic signed [23:0] dn_c;
  logic [13:0]        rem_c;
  logic               leap_c;
  logic signed [23:0] s1_dn;
  logic [4:0]         s1_mlen;
  logic signed [15:0] s1_back;

  assign pos_c  = 23'(s0_yy) * 23'd365 + 23'(s0_yy >> 2) + 23'(s0_q400)
                + 23'(cum_days(s0_k)) + 23'(s0_day);
  assign neg_c  = 18'(s0_q100) + 18'(EPOCH_ADJ);
  assign dn_c   = $signed({1'b0, pos_c}) - $signed({6'b0, neg_c});
  assign rem_c  = s0_year - 14'(16'(s0_qy) * 16'd100);
  // a century year is leap only when its century count is a multiple of four
  assign leap_c = (s0_year[1:0] == 2'd0) && ((rem_c != 14'd0) || (s0_qy[1:0] == 2'd0));

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_dn   <= dn_c;
      s1_mlen <= month_len(s0_month, leap_c);
      s1_back <= s0_back;
    end
  end

  // ---------------- stage 2: shifted day count and weekday digit sum
  logic signed [24:0] z_c;
  logic signed [24:0] w_c;
  logic [23:0]        wpad_c;
  logic [5:0]         wsum_c;
  logic [22:0]        s2_zp;
  logic [5:0]         s2_wsum;
  carry_t             c2;

  assign z_c    = 25'(s1_dn) - 25'(s1_back) + 25'sd146402;
  // bias by a multiple of seven so the weekday works on a positive value
  assign w_c    = 25'(s1_dn) + 25'sd700;
  assign wpad_c = {1'b0, w_c[22:0]};

  // eight is one mod seven: add up the octal digits
  always_comb begin
    wsum_c = '0;
    for (int i = 0; i < 8; i++) begin
      wsum_c = wsum_c + 6'(wpad_c[3*i +: 3]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_zp   <= z_c[22:0];
      s2_wsum <= wsum_c;
      c2      <= '{day_number: s1_dn[21:0], month_length: s1_mlen,
                   weekday: 3'd0, era: 6'd0};
    end
  end

  // ---------------- stage 3: era quotient, weekday fold
  logic [5:0]  era_c;
  logic [3:0]  ws_c;
  logic [2:0]  wd_c;
  logic [22:0] s3_zp;
  carry_t      c3;

  assign era_c = 6'((48'(s2_zp) * 48'(ERA_MUL)) >> ERA_SH);
  assign ws_c  = 4'(s2_wsum[2:0]) + 4'(s2_wsum[5:3]);
  assign wd_c  = (ws_c >= 4'd14) ? 3'd0 : (ws_c >= 4'd7) ? 3'(ws_c - 4'd7) : 3'(ws_c);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_zp <= s2_zp;
      c3    <= '{day_number: c2.day_number, month_length: c2.month_length,
                 weekday: wd_c, era: era_c};
    end
  end

  // ---------------- stage 4: day of era
  logic [17:0] s4_doe;
  carry_t      c4;

  function automatic logic [22:0] s3_era_days(input logic [5:0] e);
    return 23'(e) * 23'(ERA_DAYS);
  endfunction

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_doe <= 18'(s3_zp - 23'(s3_era_days(c3.era)));
      c4     <= c3;
    end
  end

  // ---------------- stage 5: leap corrections within the era
  logic [17:0] s5_doe;
  logic [6:0]  s5_a;
  logic [2:0]  s5_b;
  logic        s5_c;
  carry_t      c5;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_doe <= s4_doe;
      s5_a   <= 7'((40'(s4_doe) * 40'(Q1460_MUL)) >> Q1460_SH);
      s5_b   <= 3'((40'(s4_doe) * 40'(Q36524_MUL)) >> Q36524_SH);
      s5_c   <= (s4_doe == 18'(ERA_DAYS - 1));
      c5     <= c4;
    end
  end

  // ---------------- stage 6: year of era
  logic [17:0] t_c;
  logic [17:0] s6_doe;
  logic [8:0]  s6_yoe;
  carry_t      c6;

  assign t_c = s5_doe - 18'(s5_a) + 18'(s5_b) - 18'(s5_c);

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_doe <= s5_doe;
      s6_yoe <= 9'((40'(t_c) * 40'(Q365_MUL)) >> Q365_SH);
      c6     <= c5;
    end
  end

  // ---------------- stage 7: day of year (March based)
  logic [1:0]  qc_c;
  logic [17:0] yday_c;
  logic [8:0]  s7_doy;
  logic [8:0]  s7_yoe;
  carry_t      c7;

  assign qc_c   = 2'((20'(s6_yoe) * 20'(Q100Y_MUL)) >> Q100Y_SH);
  assign yday_c = 18'(s6_yoe) * 18'd365 + 18'(s6_yoe >> 2) - 18'(qc_c);

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_doy <= 9'(s6_doe - yday_c);
      s7_yoe <= s6_yoe;
      c7     <= c6;
    end
  end

  // ---------------- stage 8: month index
  logic [11:0] mnum_c;
  logic [3:0]  s8_mp;
  logic [8:0]  s8_doy;
  logic [8:0]  s8_yoe;
  carry_t      c8;

  assign mnum_c = 12'(s7_doy) * 12'd5 + 12'd2;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_mp  <= 4'((24'(mnum_c) * 24'(Q153_MUL)) >> Q153_SH);
      s8_doy <= s7_doy;
      s8_yoe <= s7_yoe;
      c8     <= c7;
    end
  end

  // ---------------- stage 9: civil date and range check, output register
  logic [4:0]  rd_c;
  logic [3:0]  rm_c;
  logic [14:0] yv_c;
  logic        ok_c;
  carry_t      c9;
  logic [13:0] s9_year;
  logic [3:0]  s9_month;
  logic [4:0]  s9_day;
  logic        s9_ok;

  assign rd_c = 5'(s8_doy - cum_days(s8_mp) + 9'd1);
  assign rm_c = (s8_mp < 4'd10) ? s8_mp + 4'd3 : s8_mp - 4'd9;
  // year held with a bias of 400 so it never goes negative
  assign yv_c = 15'(s8_yoe) + 15'(c8.era) * 15'd400 + 15'(rm_c <= 4'd2);
  assign ok_c = (yv_c >= 15'd401) && (yv_c <= 15'd10399);

  always_ff @(posedge clk) begin
    if (en[9]) begin
      c9       <= c8;
      s9_ok    <= ok_c;
      s9_year  <= ok_c ? 14'(yv_c - 15'd400) : 14'd0;
      s9_month <= ok_c ? rm_c : 4'd0;
      s9_day   <= ok_c ? rd_c : 5'd0;
    end
  end

  assign answer_valid = v[STAGES-1];
  assign day_number   = c9.day_number;
  assign weekday      = c9.weekday;
  assign month_length = c9.month_length;
  assign result_year  = s9_year;
  assign result_month = s9_month;
  assign result_day   = s9_day;
  assign result_valid = s9_ok;

endmodule

/* sv/cdoc_chk.sv */
// ----------------------------------------------------------------------------
// cdoc_chk: port-level checks for the civil date offset calculator
// Watches the answer channel and the range of the shifted date.
// ----------------------------------------------------------------------------
module cdoc_chk (
  input logic               clk,
  input logic               rst,
  input logic               date_stall,
  input logic               answer_valid,
  input logic               answer_stall,
  input logic [21:0]        day_number,
  input logic [2:0]         weekday,
  input logic [4:0]         month_length,
  input logic [13:0]        result_year,
  input logic [3:0]         result_month,
  input logic [4:0]         result_day,
  input logic               result_valid
);

  // a held word keeps its value until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    answer_valid && answer_stall |=> answer_valid && $stable(day_number)
      && $stable(weekday) && $stable(month_length) && $stable(result_valid)
      && $stable(result_year) && $stable(result_month) && $stable(result_day))
    else $error("answer word changed while stalled");

  // reset empties the pipe
  a_reset: assert property (@(posedge clk) rst |=> !answer_valid)
    else $error("answer valid straight after reset");

  // the date side only stalls when the pipe is full behind a stalled answer
  a_stall: assert property (@(posedge clk) disable iff (rst)
    date_stall |-> answer_valid && answer_stall)
    else $error("date stalled without a stalled answer");

  // an out-of-range shift reads as zeros
  a_zero: assert property (@(posedge clk) disable iff (rst)
    answer_valid && !result_valid |->
      result_year == 14'd0 && result_month == 4'd0 && result_day == 5'd0)
    else $error("invalid shifted date not cleared");

  // a valid shifted date has year, month and day fields in range, and the weekday is in range
  a_range: assert property (@(posedge clk) disable iff (rst)
    answer_valid && result_valid |->
      result_year >= 14'd1 && result_year <= 14'd9999 && result_month >= 4'd1
      && result_month <= 4'd12 && result_day >= 5'd1 && result_day <= 5'd31
      && weekday <= 3'd6)
    else $error("shifted date out of range");

endmodule

bind civil_date_offset_calculator cdoc_chk u_cdoc_chk (.*);

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench for civil_date_offset_calculator
// Drives dates with signed offsets through the valid/stall channel, predicts
// day number, weekday, month length and the shifted date for each accepted
// word, and compares every answer in order. A short table of edge dates comes
// first, then random dates under three idling patterns on both channels.
// ----------------------------------------------------------------------------
module tb_top;

  localparam longint DAYS_PER_ERA = 146097;
  localparam int     RANDOM_DATES = 400;
  localparam int     DRAIN_CYCLES = 30;

  typedef struct packed {
    logic [21:0] day_number;
    logic [2:0]  weekday;
    logic [4:0]  month_length;
    logic [13:0] result_year;
    logic [3:0]  result_month;
    logic [4:0]  result_day;
    logic        result_valid;
  } answer_t;

  typedef struct {
    logic [13:0]        year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic signed [15:0] days_back;
    bit                 typed;
    answer_t            want;
  } date_row_t;

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               date_valid   = 1'b0;
  logic               date_stall;
  logic [13:0]        year         = '0;
  logic [3:0]         month        = '0;
  logic [4:0]         day          = '0;
  logic signed [15:0] days_back    = '0;
  logic               answer_valid;
  logic               answer_stall = 1'b0;
  logic [21:0]        day_number;
  logic [2:0]         weekday;
  logic [4:0]         month_length;
  logic [13:0]        result_year;
  logic [3:0]         result_month;
  logic [4:0]         result_day;
  logic               result_valid;

  answer_t   pending_answers[$];
  date_row_t edge_dates[$];
  int        mismatches     = 0;
  int        answers_seen   = 0;
  int        invalid_seen   = 0;
  int        dates_sent     = 0;
  int        sender_idle_pct = 0;
  int        stall_pct       = 0;

  civil_date_offset_calculator dut (
    .clk          (clk),
    .rst          (rst),
    .date_valid   (date_valid),
    .date_stall   (date_stall),
    .year         (year),
    .month        (month),
    .day          (day),
    .days_back    (days_back),
    .answer_valid (answer_valid),
    .answer_stall (answer_stall),
    .day_number   (day_number),
    .weekday      (weekday),
    .month_length (month_length),
    .result_year  (result_year),
    .result_month (result_month),
    .result_day   (result_day),
    .result_valid (result_valid)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  // zero for months that carry no meaning
  function automatic longint days_in_month(input longint yr, input longint mo);
    bit leap;
    leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    case (mo) inside
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic answer_t civil_answer(input logic [13:0] y, input logic [3:0] m,
                                           input logic [4:0] d,
                                           input logic signed [15:0] back);
    longint  yr, mo, dd, bk, serial, wd, z, era, doe, yoe, doy, mp, rm, rd, ry;
    answer_t a;
    yr = y;
    mo = m;
    dd = d;
    bk = back;
    // count January and February as months 13 and 14 of the year before
    if (mo <= 2) begin
      yr = yr - 1;
      mo = mo + 12;
    end
    yr = yr + 400;
    serial = 365 * yr + yr / 4 - yr / 100 + yr / 400 + (153 * (mo - 3) + 2) / 5 + dd
             - 306 - DAYS_PER_ERA;
    wd = serial % 7;
    if (wd < 0) wd = wd + 7;

    // back to a civil date, counting from 0000-03-01
    z   = serial - bk + 305;
    era = (z >= 0 ? z : z - (DAYS_PER_ERA - 1)) / DAYS_PER_ERA;
    doe = z - era * DAYS_PER_ERA;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    rd  = doy - (153 * mp + 2) / 5 + 1;
    rm  = mp < 10 ? mp + 3 : mp - 9;
    ry  = yoe + era * 400 + (rm <= 2 ? 1 : 0);

    a.day_number   = serial[21:0];
    a.weekday      = wd[2:0];
    a.month_length = 5'(days_in_month(longint'(y), longint'(m)));
    a.result_valid = (ry >= 1) && (ry <= 9999);
    a.result_year  = a.result_valid ? ry[13:0] : '0;
    a.result_month = a.result_valid ? rm[3:0]  : '0;
    a.result_day   = a.result_valid ? rd[4:0]  : '0;
    return a;
  endfunction

  function automatic void plain_row(input logic [13:0] y, input logic [3:0] m,
                                    input logic [4:0] d, input logic signed [15:0] b);
    date_row_t r;
    r.year      = y;
    r.month     = m;
    r.day       = d;
    r.days_back = b;
    r.typed     = 1'b0;
    r.want      = '0;
    edge_dates.insert(edge_dates.size(), r);
  endfunction

  function automatic void known_row(input logic [13:0] y, input logic [3:0] m,
                                    input logic [4:0] d, input logic signed [15:0] b,
                                    input logic [21:0] dn, input logic [2:0] wd,
                                    input logic [4:0] ml, input logic [13:0] ry,
                                    input logic [3:0] rm, input logic [4:0] rd,
                                    input logic rv);
    date_row_t r;
    r.year      = y;
    r.month     = m;
    r.day       = d;
    r.days_back = b;
    r.typed     = 1'b1;
    r.want.day_number   = dn;
    r.want.weekday      = wd;
    r.want.month_length = ml;
    r.want.result_year  = ry;
    r.want.result_month = rm;
    r.want.result_day   = rd;
    r.want.result_valid = rv;
    edge_dates.insert(edge_dates.size(), r);
  endfunction

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // hold the word until it is taken, then log its answer
  task automatic send_date(input logic [13:0] y, input logic [3:0] m, input logic [4:0] d,
                           input logic signed [15:0] b, input answer_t want);
    while ($urandom_range(99) < sender_idle_pct) begin
      date_valid <= 1'b0;
      @(negedge clk);
    end
    date_valid <= 1'b1;
    year       <= y;
    month      <= m;
    day        <= d;
    days_back  <= b;
    @(posedge clk);
    while (date_stall) @(posedge clk);
    pending_answers.insert(pending_answers.size(), want);
    dates_sent++;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    answer_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin : answer_check
    answer_t want;
    if (!rst && answer_valid && !answer_stall) begin
      if (pending_answers.size() == 0) begin
        $error("answer word with no date outstanding");
        mismatches++;
      end else begin
        want = pending_answers.pop_front();
        check_field("day_number",   want.day_number,   day_number);
        check_field("weekday",      want.weekday,      weekday);
        check_field("month_length", want.month_length, month_length);
        check_field("result_year",  want.result_year,  result_year);
        check_field("result_month", want.result_month, result_month);
        check_field("result_day",   want.result_day,   result_day);
        check_field("result_valid", want.result_valid, result_valid);
        answers_seen++;
        if (!want.result_valid) invalid_seen++;
      end
    end
  end

  initial begin : stimulus
    logic [13:0]        y;
    logic [3:0]         m;
    logic [4:0]         d;
    logic signed [15:0] b;
    int                 pick;

    // first and last representable days with their neighbours, and the Unix epoch
    known_row(14'd1,    4'd1,  5'd1,  16'sd0,  22'd1,       3'd1, 5'd31, 14'd1,    4'd1,  5'd1,  1'b1);
    known_row(14'd1,    4'd1,  5'd1,  16'sd1,  22'd1,       3'd1, 5'd31, 14'd0,    4'd0,  5'd0,  1'b0);
    known_row(14'd9999, 4'd12, 5'd31, 16'sd0,  22'd3652059, 3'd5, 5'd31, 14'd9999, 4'd12, 5'd31, 1'b1);
    known_row(14'd9999, 4'd12, 5'd31, -16'sd1, 22'd3652059, 3'd5, 5'd31, 14'd0,    4'd0,  5'd0,  1'b0);
    known_row(14'd1970, 4'd1,  5'd1,  16'sd0,  22'd719163,  3'd4, 5'd31, 14'd1970, 4'd1,  5'd1,  1'b1);
    // leap rule: every fourth year, not centuries, but every fourth century
    plain_row(14'd2000, 4'd2,  5'd29, 16'sd0);
    plain_row(14'd1900, 4'd2,  5'd28, -16'sd1);
    plain_row(14'd2100, 4'd2,  5'd1,  16'sd0);
    plain_row(14'd2024, 4'd2,  5'd29, 16'sd366);
    plain_row(14'd400,  4'd2,  5'd29, 16'sd0);
    // unchecked dates: months without meaning, day 0, overflowing days
    plain_row(14'd2023, 4'd0,  5'd15, 16'sd0);
    plain_row(14'd2023, 4'd13, 5'd1,  16'sd0);
    plain_row(14'd2023, 4'd15, 5'd31, 16'sd0);
    plain_row(14'd2023, 4'd3,  5'd0,  16'sd0);
    plain_row(14'd2023, 4'd2,  5'd31, 16'sd0);
    // year 0, serial below 1 and serial past the 22-bit range
    plain_row(14'd0,     4'd1,  5'd1,  16'sd0);
    plain_row(14'd0,     4'd0,  5'd0,  16'sd0);
    plain_row(14'd16383, 4'd15, 5'd31, 16'sd0);
    plain_row(14'd16383, 4'd15, 5'd31, -16'sd32768);
    plain_row(14'd10000, 4'd1,  5'd1,  16'sd0);
    // offset extremes and shifts across the edges of the valid range
    plain_row(14'd5000, 4'd6,  5'd15, 16'sd32767);
    plain_row(14'd5000, 4'd6,  5'd15, -16'sd32768);
    plain_row(14'd1,    4'd3,  5'd1,  16'sd59);
    plain_row(14'd1,    4'd3,  5'd1,  16'sd60);
    plain_row(14'd9999, 4'd10, 5'd1,  -16'sd92);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    sender_idle_pct = 6;
    stall_pct       = 65;
    foreach (edge_dates[i]) begin
      send_date(edge_dates[i].year, edge_dates[i].month, edge_dates[i].day,
                edge_dates[i].days_back,
                edge_dates[i].typed ? edge_dates[i].want
                                    : civil_answer(edge_dates[i].year, edge_dates[i].month,
                                                   edge_dates[i].day,
                                                   edge_dates[i].days_back));
    end

    for (int n = 0; n < RANDOM_DATES; n++) begin
      if (n == RANDOM_DATES / 3) begin
        sender_idle_pct = 65;
        stall_pct       = 6;
      end else if (n == 2 * RANDOM_DATES / 3) begin
        sender_idle_pct = 0;
        stall_pct       = 0;
      end
      pick = $urandom_range(99);
      if (pick < 80) begin
        // real calendar dates, a share of them close to either end of the range
        case ($urandom_range(5))
          0:       y = 14'($urandom_range(100, 1));
          1:       y = 14'($urandom_range(9999, 9900));
          default: y = 14'($urandom_range(9999, 1));
        endcase
        m = 4'($urandom_range(12, 1));
        d = 5'($urandom_range(32'(days_in_month(longint'(y), longint'(m))), 1));
        if ($urandom_range(1)) b = 16'($urandom_range(800) - 400);
        else b = 16'($urandom_range(65535));
      end else begin
        y = 14'($urandom_range(16383));
        m = 4'($urandom_range(15));
        d = 5'($urandom_range(31));
        b = 16'($urandom_range(65535));
      end
      send_date(y, m, d, b, civil_answer(y, m, d, b));
    end
    date_valid <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d dates (%0d edge cases, %0d random) under three idling patterns",
             dates_sent, edge_dates.size(), RANDOM_DATES);
    $display("Checked %0d answers, %0d of them with the shifted date out of range",
             answers_seen, invalid_seen);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
sv/cdoc_pkg.sv
sv/civil_date_offset_calculator.sv
sv/cdoc_chk.sv
dv/tb_top.sv
